### hdl/mcm_pkg.sv
`timescale 1ns / 1ps

package mcm_pkg;

	localparam int DIM           = 4;
	localparam int DATA_W        = 32;
	localparam int COL_W         = 2;
	localparam int IDX_W         = 4;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int PAIR_W        = PROD_W + 1;
	localparam int SUM_W         = PROD_W + 2;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MUL  = 1'b1
	} mcm_op_t;

	typedef struct packed {
		mcm_op_t                  op;
		logic [COL_W-1:0]         col;
		logic signed [DATA_W-1:0] v0;
		logic signed [DATA_W-1:0] v1;
		logic signed [DATA_W-1:0] v2;
		logic signed [DATA_W-1:0] v3;
	} mcm_in_t;

	typedef struct packed {
		logic [COL_W-1:0]         out_col;
		logic signed [DATA_W-1:0] r0;
		logic signed [DATA_W-1:0] r1;
		logic signed [DATA_W-1:0] r2;
		logic signed [DATA_W-1:0] r3;
	} mcm_out_t;

	// stage load enables shared by all lanes
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
	} mcm_adv_t;

endpackage

### hdl/mcm_stream_if.sv
`timescale 1ns / 1ps

interface mcm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hdl/mcm_lane.sv
`timescale 1ns / 1ps

module mcm_lane import mcm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  mcm_adv_t                 adv,
	input  logic signed [DATA_W-1:0] a [DIM],
	input  logic signed [DATA_W-1:0] b [DIM],
	output logic signed [DATA_W-1:0] r
);

	logic signed [PROD_W-1:0] prod [DIM];
	logic signed [PROD_W-1:0] prod_s1 [DIM];
	logic signed [PAIR_W-1:0] pair_s2 [2];
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SUM_W-1:0]  shifted;
	logic                     in_range;

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			prod[k] = a[k] * b[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld1) begin
			prod_s1 <= prod;
		end
		if (adv.ld2) begin
			pair_s2[0] <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
			pair_s2[1] <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
		end
		if (adv.ld3) begin
			sum_s3 <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		end
	end

	// floor shift, then clamp to the signed 32-bit range
	always_comb begin
		shifted  = sum_s3 >>> FRAC_BITS;
		in_range = (&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1]);
		if (in_range) begin
			r = shifted[DATA_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

endmodule

### hdl/mcm_merge.sv
`timescale 1ns / 1ps

module mcm_merge import mcm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     v_in,
	input  logic [COL_W-1:0]         col_in,
	input  logic signed [DATA_W-1:0] r_in [DIM],
	output logic                     take,
	mcm_stream_if.source             results
);

	logic     out_valid_q;
	mcm_out_t out_data_q;

	assign take = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take && v_in) begin
			out_data_q.out_col <= col_in;
			out_data_q.r0      <= r_in[0];
			out_data_q.r1      <= r_in[1];
			out_data_q.r2      <= r_in[2];
			out_data_q.r3      <= r_in[3];
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

endmodule

### hdl/matrix4_column_multiply_top.sv
`timescale 1ns / 1ps

// 4x4 column-major matrix product R = A*B in signed fixed point with FRAC_BITS
// fraction bits. An item with op load writes column col of A into a register
// store that reset clears to zero; it gives no result. An item with op mul carries
// column col of B and gives column col of R: each row is the full-width sum of
// four products, shifted right arithmetically (toward minus infinity) by
// FRAC_BITS and saturated to signed 32 bits. One item is taken every cycle while
// stage one can load; a mul transaction passes through the product register,
// loaded at the accepting edge, then the pair add, the final add and the output
// register that takes the shift/saturate. A load is seen by every mul accepted
// in a later cycle. Four row lanes run side by side and the
// output stage merges their rows into one result. Backpressure stalls only the
// stages that are full, so bubbles are squeezed out.

module matrix4_column_multiply_top import mcm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mcm_stream_if.sink   items,
	mcm_stream_if.source results
);

	// stored A, entry {col, row}
	logic signed [DATA_W-1:0] left_q [DIM*DIM];

	logic             v_s1, v_s2, v_s3;
	logic [COL_W-1:0] col_s1, col_s2, col_s3;
	mcm_adv_t         adv;
	logic             take;
	logic             accept;
	mcm_in_t          item;

	logic signed [DATA_W-1:0] b_vec [DIM];
	logic signed [DATA_W-1:0] a_lane [DIM][DIM];
	logic signed [DATA_W-1:0] r_lane [DIM];

	assign item = items.data;

	// a stage loads when it is empty or its content moves on
	assign adv.ld3    = !v_s3 || take;
	assign adv.ld2    = !v_s2 || adv.ld3;
	assign adv.ld1    = !v_s1 || adv.ld2;
	assign items.ready = adv.ld1;
	assign accept      = items.valid && items.ready;

	assign b_vec[0] = item.v0;
	assign b_vec[1] = item.v1;
	assign b_vec[2] = item.v2;
	assign b_vec[3] = item.v3;

	// column store, written by a load transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++) begin
				left_q[i] <= '0;
			end
		end else if (accept && item.op == OP_LOAD) begin
			for (int rr = 0; rr < DIM; rr++) begin
				left_q[{item.col, 2'(rr)}] <= b_vec[rr];
			end
		end
	end

	// valid bits follow the stage enables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv.ld1) begin
				v_s1 <= accept && item.op == OP_MUL;
			end
			if (adv.ld2) begin
				v_s2 <= v_s1;
			end
			if (adv.ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld1) begin
			col_s1 <= item.col;
		end
		if (adv.ld2) begin
			col_s2 <= col_s1;
		end
		if (adv.ld3) begin
			col_s3 <= col_s2;
		end
	end

	// lane r takes row r of A: entries {k, r}
	for (genvar gr = 0; gr < DIM; gr++) begin : g_lane
		for (genvar gk = 0; gk < DIM; gk++) begin : g_tap
			assign a_lane[gr][gk] = left_q[gk*DIM + gr];
		end

		mcm_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk(clk),
			.adv(adv),
			.a  (a_lane[gr]),
			.b  (b_vec),
			.r  (r_lane[gr])
		);
	end

	mcm_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (v_s3),
		.col_in (col_s3),
		.r_in   (r_lane),
		.take   (take),
		.results(results)
	);

	// an accepted mul transaction enters stage one
	a_mul_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_MUL |=> v_s1)
		else $error("accepted mul transaction missing from stage one");

	// a load transaction never enters the pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_LOAD |=> !v_s1)
		else $error("load transaction entered the pipeline");

	// a stalled last stage keeps its item
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !take |=> v_s3 && $stable(col_s3))
		else $error("stage three lost a stalled item");

	// a load writes row zero of its column
	a_store_written: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_LOAD |=>
		left_q[{$past(item.col), 2'd0}] == $past(item.v0))
		else $error("column store not written by load");

endmodule
